// ----- hw/rtl/channel_sequence_gap_checker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Sequence gap checker assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_SEQUENCE_GAP_CHECKER_CORE_DEFINES_SVH
`define CHANNEL_SEQUENCE_GAP_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSGC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequence gap checker property failed");

// Next-cycle implication, disabled during reset
`define CSGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence gap checker property failed");

`endif

// ----- hw/rtl/csgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sequence gap checker package
// Shared widths, codes, request and result types.
// ----------------------------------------------------------------------------
package csgc_pkg;

    localparam int NUM_CHANNELS_DEF = 256;
    localparam int SEQ_BITS_DEF     = 40;
    localparam int CHAN_W           = 8;
    localparam int SEQ_W            = 40;
    localparam int QUEUE_DEPTH      = 2;
    localparam int MAX_TBL_DEPTH    = 1 << CHAN_W;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    typedef enum logic [2:0] {
        ST_FIRST      = 3'd0,
        ST_IN_ORDER   = 3'd1,
        ST_REPLAY     = 3'd2,
        ST_GAP        = 3'd3,
        ST_RESET_DONE = 3'd4
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

    typedef struct packed {
        logic              kind;
        logic              in_range;
        logic [CHAN_W-1:0] chan;
        logic [SEQ_W-1:0]  seq;
    } item_t;

    typedef struct packed {
        logic             ok;
        status_t          status;
        logic [SEQ_W-1:0] prior;
    } result_t;

    // Stored sequence width: the port carries at most SEQ_W bits
    function automatic int store_width(input int seq_bits);
        return (seq_bits < SEQ_W) ? seq_bits : SEQ_W;
    endfunction

    // Table depth: the channel field reaches at most MAX_TBL_DEPTH entries
    function automatic int table_depth(input int num_channels);
        return (num_channels < MAX_TBL_DEPTH) ? num_channels : MAX_TBL_DEPTH;
    endfunction

endpackage

// ----- hw/rtl/channel_sequence_gap_checker_core.sv -----
// ----------------------------------------------------------------------------
// Channel sequence gap checker
// Per-channel sequence tracking: first, in order, replay, gap and reset.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full with req_type, feed_chan, channel_seq.
//   Each request yields one result on seq_ok, seq_status, prior_seq, shown
//   while empty is low and taken with pop.
//   A request passes the request queue, the item and RAM read registers and
//   the result queue before its result shows.
//   A request is taken only once the last is done, set by the table RAM: a
//   read with registered data, then compare and write-back on the next cycle.
//   A 2-entry request queue and a 2-entry result queue sit on either side.
//   Reset clears both queues and every channel presence bit; the stored
//   sequence numbers are written before they are ever read.
//   When the result side stalls the result queue fills, the back end holds,
//   and full rises once the request queue is also full. Nothing is dropped.
// ----------------------------------------------------------------------------
module channel_sequence_gap_checker_core #(
    parameter int NUM_CHANNELS = csgc_pkg::NUM_CHANNELS_DEF,
    parameter int SEQ_BITS     = csgc_pkg::SEQ_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [csgc_pkg::CHAN_W-1:0] feed_chan,
    input  logic [csgc_pkg::SEQ_W-1:0]  channel_seq,
    output logic                        empty,
    input  logic                        pop,
    output logic                        seq_ok,
    output logic [2:0]                  seq_status,
    output logic [csgc_pkg::SEQ_W-1:0]  prior_seq
);

    import csgc_pkg::*;

    logic    q_empty;
    logic    deq;
    item_t   q_item;
    result_t res;

    csgc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .feed_chan   (feed_chan),
        .channel_seq (channel_seq),
        .deq         (deq),
        .q_empty     (q_empty),
        .q_item      (q_item)
    );

    csgc_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_item),
        .deq     (deq),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign seq_ok     = res.ok;
    assign seq_status = res.status;
    assign prior_seq  = res.prior;

endmodule

// ----- hw/rtl/csgc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/csgc_fifo.sv -----
// ----------------------------------------------------------------------------
// Small queue, used for both requests and results
// Register-based FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module csgc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/csgc_front.sv -----
// ----------------------------------------------------------------------------
// Sequence gap checker front end
// Accepts requests, range-checks the channel, masks the sequence, queues.
// ----------------------------------------------------------------------------
module csgc_front #(
    parameter int NUM_CHANNELS = csgc_pkg::NUM_CHANNELS_DEF,
    parameter int SEQ_BITS     = csgc_pkg::SEQ_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [csgc_pkg::CHAN_W-1:0] feed_chan,
    input  logic [csgc_pkg::SEQ_W-1:0]  channel_seq,
    input  logic                        deq,
    output logic                        q_empty,
    output csgc_pkg::item_t             q_item
);

    import csgc_pkg::*;

    localparam int SW = store_width(SEQ_BITS);
    localparam logic [SEQ_W-1:0] SEQ_MASK = {SEQ_W{1'b1}} >> (SEQ_W - SW);

    item_t cls_item;

    // Classify the request before it is queued
    always_comb
    begin
        cls_item.kind     = req_type;
        cls_item.in_range = (32'(feed_chan) < NUM_CHANNELS);
        cls_item.chan     = feed_chan;
        cls_item.seq      = channel_seq & SEQ_MASK;
    end

    csgc_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (cls_item),
        .pop     (deq),
        .empty   (q_empty),
        .rd_data (q_item)
    );

endmodule

// ----- hw/rtl/csgc_back.sv -----
// ----------------------------------------------------------------------------
// Sequence gap checker back end
// Looks up the channel table, decides the status, updates and queues results.
// ----------------------------------------------------------------------------
module csgc_back #(
    parameter int NUM_CHANNELS = csgc_pkg::NUM_CHANNELS_DEF,
    parameter int SEQ_BITS     = csgc_pkg::SEQ_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  csgc_pkg::item_t   q_item,
    output logic              deq,
    input  logic              pop,
    output logic              empty,
    output csgc_pkg::result_t res
);

    import csgc_pkg::*;

    localparam int SW    = store_width(SEQ_BITS);
    localparam int DEPTH = table_depth(NUM_CHANNELS);
    localparam int AW    = $clog2(DEPTH);

    back_state_t       state_reg, state_next;
    item_t             item_reg;
    logic [DEPTH-1:0]  seen_reg, seen_next;
    logic              rq_full, rq_push;
    result_t           rq_data;
    logic              ram_we;
    logic [SW-1:0]     ram_wdata;
    logic [SW-1:0]     ram_rdata;
    logic [AW-1:0]     lk_addr;
    logic              lk_seen;
    logic [SW-1:0]     lk_last;
    logic [SW:0]       lk_last_inc;
    logic [SW-1:0]     lk_seq;
    logic              start;

    assign start   = (state_reg == BK_IDLE) && !q_empty && !rq_full;
    assign lk_addr = item_reg.chan[AW-1:0];
    assign lk_seen = seen_reg[lk_addr];
    assign lk_last = lk_seen ? ram_rdata : '0;
    assign lk_last_inc = {1'b0, lk_last} + 1'b1;
    assign lk_seq  = item_reg.seq[SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   state_next = start ? BK_LOOKUP : BK_IDLE;
            BK_LOOKUP: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        deq       = 1'b0;
        rq_push   = 1'b0;
        rq_data   = '{ok: 1'b0, status: ST_REPLAY, prior: '0};
        ram_we    = 1'b0;
        ram_wdata = lk_seq;
        seen_next = seen_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                deq = start;
            end
            BK_LOOKUP:
            begin
                rq_push = 1'b1;
                if (!item_reg.in_range)
                begin
                    // out-of-range channel: answer replay, touch nothing
                    rq_data = '{ok: 1'b0, status: ST_REPLAY, prior: '0};
                end
                else if (item_reg.kind == REQ_RESET)
                begin
                    ram_we             = 1'b1;
                    ram_wdata          = '0;
                    seen_next[lk_addr] = 1'b1;
                    rq_data = '{ok: 1'b1, status: ST_RESET_DONE, prior: SEQ_W'(lk_last)};
                end
                else if (!lk_seen)
                begin
                    ram_we             = 1'b1;
                    seen_next[lk_addr] = 1'b1;
                    rq_data = '{ok: 1'b1, status: ST_FIRST, prior: '0};
                end
                else if ({1'b0, lk_seq} == lk_last_inc)
                begin
                    ram_we  = 1'b1;
                    rq_data = '{ok: 1'b1, status: ST_IN_ORDER, prior: SEQ_W'(lk_last)};
                end
                else if (lk_seq <= lk_last)
                begin
                    rq_data = '{ok: 1'b0, status: ST_REPLAY, prior: SEQ_W'(lk_last)};
                end
                else
                begin
                    // gap: store the new number so the channel resyncs
                    ram_we  = 1'b1;
                    rq_data = '{ok: 1'b0, status: ST_GAP, prior: SEQ_W'(lk_last)};
                end
            end
            default:
            begin
                deq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            item_reg <= q_item;
        end
    end

    csgc_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (lk_addr),
        .wr_data (ram_wdata),
        .rd_en   (deq),
        .rd_addr (q_item.chan[AW-1:0]),
        .rd_data (ram_rdata)
    );

    csgc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .full    (rq_full),
        .wr_data (rq_data),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res)
    );

endmodule

// ----- hw/rtl/csgc_checker.sv -----
// ----------------------------------------------------------------------------
// Sequence gap checker port checker
// Port-level properties on the request and result sides, bound to the top level.
// ----------------------------------------------------------------------------
`include "channel_sequence_gap_checker_core_defines.svh"

module csgc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic                        seq_ok,
    input logic [2:0]                  seq_status,
    input logic [csgc_pkg::SEQ_W-1:0]  prior_seq
);

    import csgc_pkg::*;

    logic good_status;

    assign good_status = (seq_status == ST_FIRST) || (seq_status == ST_IN_ORDER) ||
                         (seq_status == ST_RESET_DONE);

    // hold a stalled result
    `CSGC_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable({seq_ok, seq_status, prior_seq}))

    // accept flag follows the status
    `CSGC_ASSERT_SAME(a_ok_status, !empty, seq_ok == good_status)

    // a first message reports no prior number
    `CSGC_ASSERT_SAME(a_first_prior, !empty && seq_status == ST_FIRST, prior_seq == '0)

    // full only rises after a request is taken
    `CSGC_ASSERT_NEXT(a_full_needs_push, !full && !push, !full)

endmodule

bind channel_sequence_gap_checker_core csgc_checker u_csgc_checker (.*);
